FILE: rtl/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and codes for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned NumCells = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_SATURATE = 2'd2
  } status_e;

  // One classified matrix, handed from the front end to the divider lanes
  typedef struct packed {
    logic [NumCells-1:0][31:0] adj_mag;
    logic [NumCells-1:0]       neg;
    logic [NumCells-1:0]       ovf;
    logic [47:0]               det_mag;
    logic signed [49:0]        det;
    logic                      singular;
  } q_item_t;

endpackage

FILE: rtl/m3inv_front.sv
// ----------------------------------------------------------------------------
// m3inv_front
// Adjugate and determinant pipeline with classification of each matrix.
// ----------------------------------------------------------------------------
module m3inv_front import m3inv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic signed [15:0] m_i [NumCells],
  output logic               valid_o,
  input  logic               ready_i,
  output q_item_t            item_o
);

  logic [4:0] v_q;
  logic [4:0] rdy;

  assign rdy[4]  = !v_q[4] || ready_i;
  assign rdy[3]  = !v_q[3] || rdy[4];
  assign rdy[2]  = !v_q[2] || rdy[3];
  assign rdy[1]  = !v_q[1] || rdy[2];
  assign rdy[0]  = !v_q[0] || rdy[1];
  assign ready_o = rdy[0];
  assign valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
    end
  end

  // stage 1: minor products
  logic signed [31:0] pa_q [NumCells];
  logic signed [31:0] pb_q [NumCells];
  logic signed [15:0] row0_s1_q [3];
  // stage 2: adjugate
  logic signed [32:0] adj_s2_q [NumCells];
  logic signed [15:0] row0_s2_q [3];
  // stage 3: determinant terms
  logic signed [32:0] adj_s3_q [NumCells];
  logic signed [48:0] term_q [3];
  // stage 4: determinant
  logic signed [32:0] adj_s4_q [NumCells];
  logic signed [49:0] det_q;
  // stage 5: classified item
  q_item_t item_q;

  for (genvar i = 0; i < NumCells; i++) begin : g_cof
    // adj(r,c) is the cofactor of row c, column r
    localparam int R  = i % 3;
    localparam int C  = i / 3;
    localparam int R0 = (C == 0) ? 1 : 0;
    localparam int R1 = (C == 2) ? 1 : 2;
    localparam int C0 = (R == 0) ? 1 : 0;
    localparam int C1 = (R == 2) ? 1 : 2;
    localparam bit Neg = ((R + C) % 2) == 1;

    logic signed [32:0] minor;
    assign minor = 33'(pa_q[i]) - 33'(pb_q[i]);

    always_ff @(posedge clk_i) begin
      if (rdy[0] && valid_i) begin
        pa_q[i] <= m_i[R0 + 3*C0] * m_i[R1 + 3*C1];
        pb_q[i] <= m_i[R0 + 3*C1] * m_i[R1 + 3*C0];
      end
      if (rdy[1] && v_q[0]) adj_s2_q[i] <= Neg ? -minor : minor;
      if (rdy[2] && v_q[1]) adj_s3_q[i] <= adj_s2_q[i];
      if (rdy[3] && v_q[2]) adj_s4_q[i] <= adj_s3_q[i];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row0
    always_ff @(posedge clk_i) begin
      if (rdy[0] && valid_i) row0_s1_q[j] <= m_i[3*j];
      if (rdy[1] && v_q[0])  row0_s2_q[j] <= row0_s1_q[j];
      // expansion along row 0: cof(0,j) is adj(j,0)
      if (rdy[2] && v_q[1])  term_q[j] <= row0_s2_q[j] * adj_s2_q[j];
    end
  end

  logic signed [50:0] det_sum;
  assign det_sum = 51'(term_q[0]) + 51'(term_q[1]) + 51'(term_q[2]);

  logic [49:0] det_abs;
  assign det_abs = det_q[49] ? 50'(-det_q) : 50'(det_q);

  q_item_t item_d;
  always_comb begin
    logic [32:0] a;
    item_d          = item_q;
    item_d.det      = det_q;
    item_d.det_mag  = det_abs[47:0];
    item_d.singular = (det_q == '0);
    for (int i = 0; i < NumCells; i++) begin
      a                 = adj_s4_q[i][32] ? 33'(-adj_s4_q[i]) : 33'(adj_s4_q[i]);
      item_d.adj_mag[i] = a[31:0];
      item_d.neg[i]     = adj_s4_q[i][32] ^ det_q[49];
      // quotient reaches 2^16 when |adj| >= |det|
      item_d.ovf[i]     = {16'd0, a[31:0]} >= det_abs[47:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) det_q <= det_sum[49:0];
    if (rdy[4] && v_q[3]) item_q <= item_d;
  end

  assign item_o = item_q;

endmodule

FILE: rtl/m3inv_queue.sv
// ----------------------------------------------------------------------------
// m3inv_queue
// Two-entry queue between the front end and the divider lanes.
// ----------------------------------------------------------------------------
module m3inv_queue import m3inv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  q_item_t item_i,
  output logic    valid_o,
  input  logic    ready_i,
  output q_item_t item_o
);

  q_item_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

endmodule

FILE: rtl/m3inv_back.sv
// ----------------------------------------------------------------------------
// m3inv_back
// Nine restoring divider lanes, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module m3inv_back import m3inv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  q_item_t         item_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [15:0]     inv_o [NumCells],
  output logic [49:0]     det_o,
  output status_e         status_o
);

  localparam int unsigned Steps = 16;

  typedef struct packed {
    logic [NumCells-1:0][47:0] rem;
    logic [NumCells-1:0][15:0] quo;
    logic [NumCells-1:0]       neg;
    logic [NumCells-1:0]       ovf;
    logic [47:0]               dmag;
    logic [49:0]               det;
    logic                      singular;
  } div_t;

  function automatic logic [48:0] div_step(logic [47:0] r, logic [47:0] d);
    logic [48:0] t;
    logic [48:0] s;
    t = {r, 1'b0};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) return {1'b1, s[47:0]};
    else return {1'b0, t[47:0]};
  endfunction

  logic [Steps-1:0] v_q;
  logic [Steps:0]   rdy;
  div_t             st_q [Steps];
  div_t             src [Steps];
  logic [Steps-1:0] src_v;
  logic             out_v_q;

  assign rdy[Steps] = !out_v_q || ready_i;
  assign ready_o    = rdy[0];

  always_comb begin
    src[0]          = '0;
    src[0].neg      = item_i.neg;
    src[0].ovf      = item_i.ovf;
    src[0].dmag     = item_i.det_mag;
    src[0].det      = item_i.det;
    src[0].singular = item_i.singular;
    for (int i = 0; i < NumCells; i++) begin
      src[0].rem[i] = {16'd0, item_i.adj_mag[i]};
    end
  end
  assign src_v[0] = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign src[k]   = st_q[k-1];
      assign src_v[k] = v_q[k-1];
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    div_t nxt;
    always_comb begin
      logic [48:0] r;
      nxt = src[k];
      for (int i = 0; i < NumCells; i++) begin
        r          = div_step(src[k].rem[i], src[k].dmag);
        nxt.rem[i] = r[47:0];
        nxt.quo[i] = {src[k].quo[i][14:0], r[48]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_v[k]) st_q[k] <= nxt;
    end
  end

  // saturation and output register
  logic [15:0] inv_d [NumCells];
  logic        sat_d;
  always_comb begin
    logic sat;
    logic [15:0] mag;
    sat_d = 1'b0;
    for (int i = 0; i < NumCells; i++) begin
      mag = st_q[Steps-1].quo[i];
      if (st_q[Steps-1].neg[i]) begin
        sat      = st_q[Steps-1].ovf[i] || (mag > 16'h8000);
        inv_d[i] = sat ? 16'h8000 : 16'(-mag);
      end else begin
        sat      = st_q[Steps-1].ovf[i] || mag[15];
        inv_d[i] = sat ? 16'h7fff : mag;
      end
      if (st_q[Steps-1].singular) inv_d[i] = '0;
      sat_d = sat_d | sat;
    end
  end

  logic [15:0] inv_q [NumCells];
  logic [49:0] det_q;
  status_e     status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy[Steps]) begin
      out_v_q <= v_q[Steps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[Steps] && v_q[Steps-1]) begin
      inv_q <= inv_d;
      det_q <= st_q[Steps-1].det;
      if (st_q[Steps-1].singular) status_q <= ST_SINGULAR;
      else if (sat_d)             status_q <= ST_SATURATE;
      else                        status_q <= ST_OK;
    end
  end

  assign valid_o  = out_v_q;
  assign inv_o    = inv_q;
  assign det_o    = det_q;
  assign status_o = status_q;

endmodule

FILE: rtl/matrix3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 Q8.8 matrix inverse by adjugate and exact determinant.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one result per clock when neither
// side stalls. The path runs through five front-end stages (minor products,
// adjugate, determinant terms, determinant sum, classification), the
// two-entry queue, sixteen restoring divider stages (one quotient bit each
// across nine parallel lanes) and the saturating output register. Either side
// may stall without stopping the other until the queue fills.
module matrix3_inverse_core import m3inv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] in_e0_i,
  input  logic [15:0] in_e1_i,
  input  logic [15:0] in_e2_i,
  input  logic [15:0] in_e3_i,
  input  logic [15:0] in_e4_i,
  input  logic [15:0] in_e5_i,
  input  logic [15:0] in_e6_i,
  input  logic [15:0] in_e7_i,
  input  logic [15:0] in_e8_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] inv_e0_o,
  output logic [15:0] inv_e1_o,
  output logic [15:0] inv_e2_o,
  output logic [15:0] inv_e3_o,
  output logic [15:0] inv_e4_o,
  output logic [15:0] inv_e5_o,
  output logic [15:0] inv_e6_o,
  output logic [15:0] inv_e7_o,
  output logic [15:0] inv_e8_o,
  output logic [49:0] det_value_o,
  output logic [1:0]  status_o
);

  logic signed [15:0] m [NumCells];
  logic [15:0]        inv [NumCells];
  logic               f_valid, f_ready, b_valid, b_ready;
  q_item_t            f_item, b_item;
  status_e            status;

  assign m[0] = in_e0_i;
  assign m[1] = in_e1_i;
  assign m[2] = in_e2_i;
  assign m[3] = in_e3_i;
  assign m[4] = in_e4_i;
  assign m[5] = in_e5_i;
  assign m[6] = in_e6_i;
  assign m[7] = in_e7_i;
  assign m[8] = in_e8_i;

  m3inv_front u_front (
    .clk_i, .rst_ni,
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .m_i     (m),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .item_o  (f_item)
  );

  m3inv_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i (f_valid),
    .ready_o (f_ready),
    .item_i  (f_item),
    .valid_o (b_valid),
    .ready_i (b_ready),
    .item_o  (b_item)
  );

  m3inv_back u_back (
    .clk_i, .rst_ni,
    .valid_i  (b_valid),
    .ready_o  (b_ready),
    .item_i   (b_item),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .inv_o    (inv),
    .det_o    (det_value_o),
    .status_o (status)
  );

  assign inv_e0_o = inv[0];
  assign inv_e1_o = inv[1];
  assign inv_e2_o = inv[2];
  assign inv_e3_o = inv[3];
  assign inv_e4_o = inv[4];
  assign inv_e5_o = inv[5];
  assign inv_e6_o = inv[6];
  assign inv_e7_o = inv[7];
  assign inv_e8_o = inv[8];
  assign status_o = status;

endmodule

FILE: rtl/m3inv_checker.sv
// ----------------------------------------------------------------------------
// m3inv_checker
// Port-level checks on the inverse core results, bound to the top level.
// ----------------------------------------------------------------------------
module m3inv_checker import m3inv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] inv_e0_o,
  input logic [15:0] inv_e4_o,
  input logic [15:0] inv_e8_o,
  input logic [49:0] det_value_o,
  input logic [1:0]  status_o
);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(det_value_o))
    else $error("result dropped or changed while stalled");

  a_sing_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SINGULAR |-> det_value_o == '0)
    else $error("singular transaction with non-zero determinant");

  a_sing_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SINGULAR |->
      inv_e0_o == '0 && inv_e4_o == '0 && inv_e8_o == '0)
    else $error("singular transaction with non-zero elements");

  a_ok_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK || status_o == ST_SATURATE) |->
      det_value_o != '0)
    else $error("zero determinant not flagged singular");

endmodule

bind matrix3_inverse_core m3inv_checker u_m3inv_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i,
  .inv_e0_o, .inv_e4_o, .inv_e8_o, .det_value_o, .status_o
);
